/* rtl/core/rsd_pkg.sv */
// shared types and codes for the run skip dump frame decoder
`timescale 1ns / 1ps

package rsd_pkg;

	// command kinds on the result word
	localparam logic [1:0] KIND_LITERAL = 2'd0;
	localparam logic [1:0] KIND_SPAN    = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// classified operations passed from parser to executor
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_SKIP    = 3'd1;
	localparam logic [2:0] OP_SPAN    = 3'd2;
	localparam logic [2:0] OP_LITERAL = 3'd3;
	localparam logic [2:0] OP_END     = 3'd4;

	// stream constants
	localparam logic [7:0]  LONG_OP_MARK = 8'h80;
	localparam logic [6:0]  SHORT_MASK   = 7'h7F;
	localparam logic [14:0] LONG_MASK    = 15'h7FFF;
	localparam logic [13:0] COUNT_MASK   = 14'h3FFF;

	// operation queue geometry
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	// configuration register index
	localparam logic REG_CANVAS = 1'b0;

	// one queued operation
	typedef struct packed {
		logic        clr;    // frame start: address back to zero first
		logic [2:0]  kind;   // operation code
		logic [14:0] count;  // skip distance or span length
		logic [7:0]  pix;    // palette index
	} q_entry_t;

	// queue status towards both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* rtl/core/rsd_front.sv */
// byte parser: tracks the stream phase and classifies each byte into an operation
`timescale 1ns / 1ps

module rsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	output logic               push,
	output rsd_pkg::q_entry_t  entry
);

	localparam logic [2:0] PH_OPCODE    = 3'd0;
	localparam logic [2:0] PH_RUN_COUNT = 3'd1;
	localparam logic [2:0] PH_RUN_PIXEL = 3'd2;
	localparam logic [2:0] PH_LONG_LO   = 3'd3;
	localparam logic [2:0] PH_LONG_HI   = 3'd4;
	localparam logic [2:0] PH_LONG_PIX  = 3'd5;
	localparam logic [2:0] PH_DUMP      = 3'd6;

	logic [2:0]  phase_q;
	logic [13:0] pend_q;
	logic [7:0]  low_q;
	logic        fin_q;

	logic [2:0]  phase_cur;
	logic [13:0] pend_cur;
	logic        fin_cur;
	logic [2:0]  phase_nxt;
	logic [13:0] pend_nxt;
	logic [7:0]  low_nxt;
	logic        fin_nxt;
	logic [15:0] long_op;
	logic [13:0] pend_dec;

	assign long_op  = {data_byte, low_q};
	assign pend_dec = pend_cur - 14'd1;

	// frame start clears the parser before the byte is looked at
	always_comb begin
		phase_cur = frame_start ? PH_OPCODE : phase_q;
		pend_cur  = frame_start ? 14'd0 : pend_q;
		fin_cur   = frame_start ? 1'b0 : fin_q;
	end

	// classify the byte
	always_comb begin
		phase_nxt   = phase_cur;
		pend_nxt    = pend_cur;
		low_nxt     = low_q;
		fin_nxt     = fin_cur;
		entry.clr   = frame_start;
		entry.kind  = rsd_pkg::OP_NONE;
		entry.count = 15'd0;
		entry.pix   = data_byte;
		if (!fin_cur) begin
			unique case (phase_cur) inside
				PH_OPCODE: begin
					if (data_byte == 8'd0) begin
						phase_nxt = PH_RUN_COUNT;
					end else if (data_byte[7]) begin
						if ((data_byte[6:0] & rsd_pkg::SHORT_MASK) == 7'd0) begin
							phase_nxt = PH_LONG_LO;
						end else begin
							entry.kind  = rsd_pkg::OP_SKIP;
							entry.count = {8'd0, data_byte[6:0]};
						end
					end else begin
						pend_nxt  = {7'd0, data_byte[6:0]};
						phase_nxt = PH_DUMP;
					end
				end
				PH_RUN_COUNT: begin
					pend_nxt  = {6'd0, data_byte};
					phase_nxt = PH_RUN_PIXEL;
				end
				PH_RUN_PIXEL, PH_LONG_PIX: begin
					phase_nxt = PH_OPCODE;
					if (pend_cur != 14'd0) begin
						entry.kind  = rsd_pkg::OP_SPAN;
						entry.count = {1'b0, pend_cur};
						pend_nxt    = 14'd0;
					end
				end
				PH_LONG_LO: begin
					low_nxt   = data_byte;
					phase_nxt = PH_LONG_HI;
				end
				PH_LONG_HI: begin
					phase_nxt = PH_OPCODE;
					if (long_op == 16'd0) begin
						entry.kind  = rsd_pkg::OP_END;
						entry.pix   = 8'd0;
						fin_nxt     = 1'b1;
					end else if (!long_op[15]) begin
						entry.kind  = rsd_pkg::OP_SKIP;
						entry.count = long_op[14:0] & rsd_pkg::LONG_MASK;
					end else if (long_op[14]) begin
						pend_nxt  = long_op[13:0] & rsd_pkg::COUNT_MASK;
						phase_nxt = PH_LONG_PIX;
					end else if (long_op[13:0] != 14'd0) begin
						pend_nxt  = long_op[13:0] & rsd_pkg::COUNT_MASK;
						phase_nxt = PH_DUMP;
					end
				end
				PH_DUMP: begin
					entry.kind  = rsd_pkg::OP_LITERAL;
					entry.count = 15'd1;
					pend_nxt    = pend_dec;
					if (pend_dec == 14'd0) begin
						phase_nxt = PH_OPCODE;
					end
				end
				default: begin
					phase_nxt = PH_OPCODE;
				end
			endcase
		end
	end

	assign push = accept && (frame_start || (entry.kind != rsd_pkg::OP_NONE));

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			pend_q  <= 14'd0;
			low_q   <= 8'd0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			pend_q  <= pend_nxt;
			low_q   <= low_nxt;
			fin_q   <= fin_nxt;
		end
	end

	// a finished frame always leaves the parser at an opcode
	a_fin_phase: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (phase_q == PH_OPCODE))
		else $error("frame finished outside opcode phase");

	// a dump in progress always has bytes left
	a_dump_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DUMP) |-> (pend_q != 14'd0))
		else $error("dump phase with no bytes pending");

endmodule

/* rtl/core/rsd_queue.sv */
// short operation queue between parser and executor
`timescale 1ns / 1ps

module rsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rsd_pkg::q_entry_t  wr_entry,
	input  logic               pop,
	output rsd_pkg::q_entry_t  rd_entry,
	output rsd_pkg::q_status_t status
);

	rsd_pkg::q_entry_t               mem_q [rsd_pkg::Q_DEPTH];
	logic [rsd_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [rsd_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [rsd_pkg::Q_CNT_W-1:0]     count_q;

	assign status.full  = (count_q == rsd_pkg::Q_CNT_W'(rsd_pkg::Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_entry     = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");

endmodule

/* rtl/core/rsd_back.sv */
// executor: keeps the canvas address and builds the command words
`timescale 1ns / 1ps

module rsd_back #(
	parameter int unsigned ADDR_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        canvas_pixels,
	input  rsd_pkg::q_entry_t  op,
	input  rsd_pkg::q_status_t status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         command_kind,
	output logic [15:0]        write_address,
	output logic [13:0]        span_length,
	output logic [7:0]         pixel_value,
	output logic               out_of_range
);

	localparam int unsigned SAT_W = ADDR_WIDTH + 16;
	localparam int unsigned END_W = ADDR_WIDTH + 17;

	logic [ADDR_WIDTH-1:0] addr_q;
	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [15:0]           waddr_q;
	logic [13:0]           len_q;
	logic [7:0]            pix_q;
	logic                  oor_q;

	logic [ADDR_WIDTH-1:0] base;
	logic [SAT_W-1:0]      adv_sum;
	logic [ADDR_WIDTH-1:0] adv_addr;
	logic [13:0]           emit_len;
	logic [END_W-1:0]      end_sum;
	logic [SAT_W-1:0]      base_ext;
	logic                  emits;
	logic                  advances;
	logic                  out_free;

	assign base     = op.clr ? '0 : addr_q;
	assign base_ext = {16'd0, base};

	// saturating address advance
	assign adv_sum  = base_ext + {{(ADDR_WIDTH + 1){1'b0}}, op.count};
	assign adv_addr = (adv_sum[SAT_W-1:ADDR_WIDTH] != '0) ? {ADDR_WIDTH{1'b1}}
		: adv_sum[ADDR_WIDTH-1:0];

	// span end against canvas size
	assign emit_len = op.count[13:0];
	assign end_sum  = {17'd0, base} + {{(ADDR_WIDTH + 3){1'b0}}, emit_len};

	always_comb begin
		emits    = 1'b0;
		advances = 1'b0;
		unique case (op.kind) inside
			rsd_pkg::OP_SKIP:    advances = 1'b1;
			rsd_pkg::OP_SPAN,
			rsd_pkg::OP_LITERAL: begin
				emits    = 1'b1;
				advances = 1'b1;
			end
			rsd_pkg::OP_END:     emits = 1'b1;
			default:             emits = 1'b0;
		endcase
	end

	// a word may be loaded when the output register is empty or being taken
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !status.empty && (!emits || out_free);

	// address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (pop) begin
			addr_q <= advances ? adv_addr : base;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pop && emits;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop && emits) begin
			waddr_q <= base_ext[15:0];
			if (op.kind == rsd_pkg::OP_END) begin
				kind_q <= rsd_pkg::KIND_END;
				len_q  <= 14'd0;
				pix_q  <= 8'd0;
				oor_q  <= 1'b0;
			end else begin
				kind_q <= (op.kind == rsd_pkg::OP_SPAN) ? rsd_pkg::KIND_SPAN
					: rsd_pkg::KIND_LITERAL;
				len_q  <= emit_len;
				pix_q  <= op.pix;
				oor_q  <= (end_sum > {{(ADDR_WIDTH + 1){1'b0}}, canvas_pixels});
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign command_kind  = kind_q;
	assign write_address = waddr_q;
	assign span_length   = len_q;
	assign pixel_value   = pix_q;
	assign out_of_range  = oor_q;

	// end of frame word carries no length and no range flag
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == rsd_pkg::KIND_END)) |-> ((len_q == 14'd0) && !oor_q))
		else $error("malformed end of frame word");

	// a literal always covers one pixel
	a_literal_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == rsd_pkg::KIND_LITERAL)) |-> (len_q == 14'd1))
		else $error("literal word with length other than one");

endmodule

/* rtl/core/run_skip_dump_frame_decoder_unit.sv */
// top level of the run skip dump frame decoder with its configuration port
`timescale 1ns / 1ps

// Decodes a run/skip/dump delta frame one stream byte per word into canvas write
// commands (literal pixel, fill span, end of frame). The parser accepts one byte
// every cycle while its four-entry operation queue has room; the executor retires
// one queued operation per cycle unless the output stalls, so the sustained rate
// is one byte per cycle without output stalls. Each operation is written into the
// queue when its byte is accepted and reaches the output register when popped.
// An output stall holds only a command-producing operation at the head; the parser
// keeps taking bytes until the queue fills. canvas_pixels lies at byte address 0.

module run_skip_dump_frame_decoder_unit #(
	parameter int unsigned ADDR_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	// command words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  command_kind,
	output logic [15:0] write_address,
	output logic [13:0] span_length,
	output logic [7:0]  pixel_value,
	output logic        out_of_range
);

	logic [15:0]        canvas_q;
	logic               accept;
	logic               push;
	logic               pop;
	rsd_pkg::q_entry_t  wr_entry;
	rsd_pkg::q_entry_t  rd_entry;
	rsd_pkg::q_status_t q_status;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_q <= 16'd64000;
		end else if (psel && penable && pwrite && (paddr[2] == rsd_pkg::REG_CANVAS)) begin
			canvas_q <= pwdata[15:0];
		end
	end
	assign prdata = (paddr[2] == rsd_pkg::REG_CANVAS) ? {16'd0, canvas_q} : 32'd0;

	// input handshake
	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;

	rsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.push        (push),
		.entry       (wr_entry)
	);

	rsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (q_status)
	);

	rsd_back #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.canvas_pixels (canvas_q),
		.op            (rd_entry),
		.status        (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.command_kind  (command_kind),
		.write_address (write_address),
		.span_length   (span_length),
		.pixel_value   (pixel_value),
		.out_of_range  (out_of_range)
	);

endmodule
